### hw/rtl/tsis_pkg.sv
package tsis_pkg;

    localparam int TIME_W    = 48;
    localparam int OUT_IDX_W = 10;
    localparam int OUT_CNT_W = 11;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PROBE,
        ST_DONE
    } t_state;

endpackage

### hw/rtl/timestamp_table_interval_search.sv
// An append goes from the input transfer through ST_DONE to the output register; a query runs
// ST_START and a bisection for the first key, then ST_START and one for the second, then ST_DONE.
// One item in flight: the input is stalled until its result is registered, so a new item is
// taken only once the last one is through; output stalls hold the item in ST_DONE.
// Each probe is one synchronous RAM read compared in the next cycle, which issues the next read.
// Synchronous active-low reset clears fill count, sequencer and output valid; RAM not cleared.
module timestamp_table_interval_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_command,
    input  logic [tsis_pkg::TIME_W-1:0]    i_first_time,
    input  logic [tsis_pkg::TIME_W-1:0]    i_second_time,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tsis_pkg::OUT_IDX_W-1:0] o_start_index,
    output logic [tsis_pkg::OUT_IDX_W-1:0] o_end_index,
    output logic                           o_ok,
    output logic [tsis_pkg::OUT_CNT_W-1:0] o_entry_count
);
    import tsis_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state              r_state, n_state;
    logic [TIME_W-1:0]   r_first, r_second;
    logic [CNT_W-1:0]    r_count;
    logic                r_pass;
    logic [IDX_W-1:0]    r_lo, r_hi, r_probe, r_start_idx;
    logic [IDX_W-1:0]    r_res_start, r_res_end;
    logic                r_res_ok;
    logic [TIME_W-1:0]   r_rdata;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_start, r_out_end;
    logic                r_out_ok;
    logic [CNT_W-1:0]    r_out_count;

    logic [TIME_W-1:0]   mem [TABLE_DEPTH];

    logic                w_accept, w_full, w_few, w_out_free;
    logic [TIME_W-1:0]   w_key;
    logic                w_gt, w_eq, w_stop, w_cont;
    logic [IDX_W-1:0]    w_lo, w_hi, w_next_probe, w_cnt_m1;
    logic [IDX_W:0]      w_sum;
    logic                w_wr_en;

    logic [IDX_W+OUT_IDX_W-1:0] w_ext_start, w_ext_end;
    logic [CNT_W+OUT_CNT_W-1:0] w_ext_count;

    assign w_accept   = i_valid && !o_stall;
    assign w_full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_few      = (r_count < CNT_W'(2));
    assign w_cnt_m1   = IDX_W'(r_count - CNT_W'(1));
    assign w_out_free = !r_out_valid || !i_stall;

    // shared bisection step: compare last read and narrow bounds (initial bounds in ST_START), form next probe
    assign w_key = r_pass ? r_second : r_first;
    assign w_gt  = (r_rdata > w_key);
    assign w_eq  = (r_rdata == w_key);

    always_comb begin
        if (r_state == ST_PROBE) begin
            w_lo   = w_gt ? r_lo : r_probe;
            w_hi   = w_gt ? r_probe : r_hi;
            w_stop = w_eq;
        end else begin
            w_lo   = '0;
            w_hi   = w_cnt_m1;
            w_stop = w_few;
        end
    end

    assign w_cont       = !w_stop && (({1'b0, w_lo} + 1'b1) < {1'b0, w_hi});
    assign w_sum        = {1'b0, w_lo} + {1'b0, w_hi};
    assign w_next_probe = w_sum[IDX_W:1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_command == CMD_QUERY) ? ST_START : ST_DONE;
                end
            end
            ST_START, ST_PROBE: begin
                if (!w_cont && r_pass) begin
                    n_state = ST_DONE;
                end else if (!w_cont) begin
                    n_state = ST_START;
                end else begin
                    n_state = ST_PROBE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE);
        w_wr_en = (r_state == ST_IDLE) && w_accept && (i_command == CMD_APPEND) && !w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_first     <= i_first_time;
                    r_second    <= i_second_time;
                    r_pass      <= 1'b0;
                    r_probe     <= '0;
                    r_res_start <= '0;
                    r_res_end   <= '0;
                    r_res_ok    <= !w_full;
                end
            end
            ST_START, ST_PROBE: begin
                r_lo <= w_lo;
                r_hi <= w_hi;
                if (w_cont) begin
                    r_probe <= w_next_probe;
                end else if (!r_pass) begin
                    r_start_idx <= r_probe;
                    r_pass      <= 1'b1;
                    r_probe     <= '0;
                end else begin
                    r_res_start <= r_start_idx;
                    r_res_end   <= r_probe;
                    r_res_ok    <= (r_start_idx < r_probe);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_start <= r_res_start;
                    r_out_end   <= r_res_end;
                    r_out_ok    <= r_res_ok;
                    r_out_count <= r_count;
                end
            end
            default: begin
            end
        endcase
    end

    // timestamp RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_count[IDX_W-1:0]] <= i_first_time;
        end
        r_rdata <= mem[w_next_probe];
    end

    assign w_ext_start = {{OUT_IDX_W{1'b0}}, r_out_start};
    assign w_ext_end   = {{OUT_IDX_W{1'b0}}, r_out_end};
    assign w_ext_count = {{OUT_CNT_W{1'b0}}, r_out_count};

    assign o_valid       = r_out_valid;
    assign o_start_index = w_ext_start[OUT_IDX_W-1:0];
    assign o_end_index   = w_ext_end[OUT_IDX_W-1:0];
    assign o_ok          = r_out_ok;
    assign o_entry_count = w_ext_count[OUT_CNT_W-1:0];

endmodule
